// ===== sv/cls_pkg.sv =====
// Shared types and constants of the context load/store elimination block.
package cls_pkg;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_BARRIER = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_STORE   = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  // Width of the epoch tag that replaces a flash clear of the valid bits.
  localparam int unsigned EPOCH_BITS = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;  // capture the input beat
    logic idx_clr;    // restart the byte index
    logic rd;         // read the entry at offset plus index
    logic chk;        // check the entry just read
    logic chk_first;  // the check is the first byte of a lookup
    logic wr;         // write the item's entry at offset plus index
    logic clr_wr;     // write one invalid entry of the clearing pass
    logic epoch_inc;  // advance the epoch on a barrier
    logic out_load;   // load the result register
    logic res_hit;    // the result removes the item
  } cls_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       err;
    logic       mode;
    logic       fail;
    logic       last;
    logic       wr_last;
    logic       wrap;
    logic       clr_last;
    logic       out_busy;
  } cls_stat_t;

endpackage

// ===== sv/cls_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module cls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cls_datapath.sv =====
// Datapath: item registers, byte table memory, checks and result register.
module cls_datapath import cls_pkg::*; #(
  parameter int unsigned CONTEXT_BYTES    = 1024,
  parameter int unsigned MAX_ACCESS_BYTES = 8,
  parameter int unsigned VALUE_ID_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cls_cmd_t    cmd_i,
  output cls_stat_t   stat_o,
  input  logic        pass_mode_we_i,
  input  logic        pass_mode_i,
  input  logic [1:0]  operation_i,
  input  logic [9:0]  offset_i,
  input  logic [3:0]  size_bytes_i,
  input  logic [3:0]  type_code_i,
  input  logic [15:0] value_id_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic        remove_o,
  output logic [15:0] reuse_value_o,
  output logic        range_error_o
);

  localparam int unsigned AW = $clog2(CONTEXT_BYTES);
  localparam int unsigned CW = ((AW > 10) ? AW : 10) + 2;
  localparam int unsigned EW = EPOCH_BITS + 1 + AW + 16 + 4 + 4;
  localparam logic [CW-1:0] CB_C = CW'(CONTEXT_BYTES);
  localparam logic [4:0] MAX_C = 5'(MAX_ACCESS_BYTES);
  localparam logic [15:0] VID_MASK = (VALUE_ID_BITS >= 16) ? 16'hFFFF :
                                     16'((64'd1 << VALUE_ID_BITS) - 64'd1);

  logic                  mode_q;
  logic [1:0]            op_q;
  logic [9:0]            off_q;
  logic [3:0]            size_q;
  logic [3:0]            type_q;
  logic [15:0]           vid_q;
  logic                  err_q;
  logic [4:0]            idx_q;
  logic [4:0]            cnt_q;
  logic [15:0]           v_q;
  logic [EPOCH_BITS-1:0] epoch_q;
  logic [AW-1:0]         clr_q;
  logic                  out_valid_q;
  logic                  remove_q;
  logic [15:0]           reuse_q;
  logic                  rerr_q;

  logic [CW-1:0]         in_end;
  logic                  in_err;
  logic [CW-1:0]         off_ext;
  logic [AW-1:0]         off_a;
  logic [AW-1:0]         scan_addr;
  logic [EW-1:0]         rdata;
  logic [EW-1:0]         wdata;
  logic [EW-1:0]         fill_ent;
  logic [EW-1:0]         clr_ent;
  logic [EPOCH_BITS-1:0] r_epoch;
  logic                  r_valid;
  logic [AW-1:0]         r_start;
  logic [15:0]           r_value;
  logic [3:0]            r_type;
  logic [3:0]            r_size;
  logic                  r_live;
  logic                  first_fail;
  logic [4:0]            cnt_sel;
  logic                  fill_valid;

  // Range and size check of an incoming beat.
  assign in_end = CW'(offset_i) + CW'(size_bytes_i);
  assign in_err = ((operation_i == OP_LOAD) || (operation_i == OP_STORE)) &&
                  ((size_bytes_i == 4'd0) || ({1'b0, size_bytes_i} > MAX_C) ||
                   (in_end > CB_C));

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (pass_mode_we_i) begin
      mode_q <= pass_mode_i;
    end
  end

  // Item registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= operation_i;
      off_q  <= offset_i;
      size_q <= size_bytes_i;
      type_q <= type_code_i;
      vid_q  <= value_id_i & VID_MASK;
      err_q  <= in_err;
    end
  end

  assign off_ext   = CW'(off_q);
  assign off_a     = off_ext[AW-1:0];
  assign scan_addr = off_a + AW'(idx_q);

  // Fields of the entry just read.
  assign {r_epoch, r_valid, r_start, r_value, r_type, r_size} = rdata;
  assign r_live = r_valid && (r_epoch == epoch_q);

  // First byte of a lookup: a whole value of the same type must start here.
  assign first_fail = !r_live || (r_start != off_a) || (r_size == 4'd0) ||
                      ((off_ext + CW'(r_size)) > CB_C) || (r_type != type_q);
  assign cnt_sel = cmd_i.chk_first ? {1'b0, r_size} : cnt_q;

  // Byte index and scan count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
      v_q   <= '0;
    end else if (cmd_i.load_item) begin
      idx_q <= '0;
      cnt_q <= {1'b0, size_bytes_i};
    end else begin
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.chk || cmd_i.wr) begin
        idx_q <= idx_q + 5'd1;
      end
      if (cmd_i.chk && cmd_i.chk_first) begin
        cnt_q <= {1'b0, r_size};
        v_q   <= r_value;
      end
    end
  end

  // Epoch and clearing pass address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= '0;
      clr_q   <= '0;
    end else begin
      if (cmd_i.epoch_inc) begin
        epoch_q <= epoch_q + 1'b1;
      end
      if (cmd_i.clr_wr) begin
        clr_q <= stat_o.clr_last ? '0 : clr_q + 1'b1;
      end
    end
  end

  // Entry written by an item, and by the clearing pass.
  assign fill_valid = !(mode_q && (op_q == OP_LOAD));
  assign fill_ent   = {epoch_q, fill_valid, off_a, vid_q, type_q, size_q};
  assign clr_ent    = '0;
  assign wdata      = cmd_i.clr_wr ? clr_ent : fill_ent;

  cls_ram #(
    .WIDTH (EW),
    .DEPTH (CONTEXT_BYTES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr | cmd_i.clr_wr),
    .waddr_i (cmd_i.clr_wr ? clr_q : scan_addr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (scan_addr),
    .rdata_o (rdata)
  );

  // Result register; a beat leaves when it is not stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      remove_q <= cmd_i.res_hit;
      reuse_q  <= (cmd_i.res_hit && !mode_q && (op_q == OP_LOAD)) ? v_q : 16'd0;
      rerr_q   <= err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign remove_o      = remove_q;
  assign reuse_value_o = reuse_q;
  assign range_error_o = rerr_q;

  // Status toward the controller.
  always_comb begin
    stat_o.op       = op_q;
    stat_o.err      = err_q;
    stat_o.mode     = mode_q;
    stat_o.fail     = cmd_i.chk_first ? first_fail :
                      (!r_live || (!mode_q && (r_value != v_q)));
    stat_o.last     = (idx_q + 5'd1) == cnt_sel;
    stat_o.wr_last  = (idx_q + 5'd1) == {1'b0, size_q};
    stat_o.wrap     = &epoch_q;
    stat_o.clr_last = clr_q == AW'(CONTEXT_BYTES - 1);
    stat_o.out_busy = out_valid_q && out_stall_i;
  end

endmodule

// ===== sv/cls_ctrl.sv =====
// Controller state machine that sequences the byte scans and writes.
module cls_ctrl import cls_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  cls_stat_t stat_i,
  output cls_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_RD     = 3'd2;
  localparam logic [2:0] ST_CHK    = 3'd3;
  localparam logic [2:0] ST_WR     = 3'd4;
  localparam logic [2:0] ST_CLEAR  = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  logic [2:0] state_q, state_d;
  logic       first_q, first_d;
  logic       hit_q, hit_d;
  logic       item_q, item_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      first_q <= 1'b0;
      hit_q   <= 1'b0;
      item_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      hit_q   <= hit_d;
      item_q  <= item_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    first_d = first_q;
    hit_d   = hit_q;
    item_d  = item_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          hit_d   = 1'b0;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat_i.op == OP_BARRIER) begin
          cmd_o.epoch_inc = 1'b1;
          item_d  = 1'b1;
          state_d = stat_i.wrap ? ST_CLEAR : ST_FIN;
        end else if (stat_i.err || (stat_i.op != OP_LOAD && stat_i.op != OP_STORE)) begin
          state_d = ST_FIN;
        end else if (!stat_i.mode && (stat_i.op == OP_LOAD)) begin
          first_d = 1'b1;
          state_d = ST_RD;
        end else if (stat_i.mode && (stat_i.op == OP_STORE)) begin
          first_d = 1'b0;
          state_d = ST_RD;
        end else begin
          state_d = ST_WR;
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_CHK;
      end
      ST_CHK: begin
        cmd_o.chk_first = first_q;
        if (stat_i.fail) begin
          cmd_o.idx_clr = 1'b1;
          state_d = ST_WR;
        end else begin
          cmd_o.chk = 1'b1;
          first_d   = 1'b0;
          if (stat_i.last) begin
            hit_d   = 1'b1;
            state_d = ST_FIN;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_WR: begin
        cmd_o.wr = 1'b1;
        if (stat_i.wr_last) begin
          state_d = ST_FIN;
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = item_q ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.res_hit  = hit_q;
          item_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/context_load_store_elimination.sv =====
// Top level of the context load/store elimination block.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------------
//   input    | in_valid_i / in_stall_o    | operation, offset, size, type, value id
//   result   | out_valid_o / out_stall_i  | remove, reuse_value, range_error
//   config   | pass_mode_we_i             | pass_mode_i
//
// A bad range or an unused code goes from the decide state straight to the finish
// state, as does a barrier unless the epoch tag wraps; a fill writes one table entry
// per byte; a scan reads and then checks each byte in turn, followed by the fill on
// a miss. The byte table memory is read or written one byte at a time, with a
// registered read. After reset, and after every 256th barrier when the epoch tag
// wraps, a clearing pass writes all CONTEXT_BYTES entries while the input is stalled.
// A stalled result is held in the output register while the next beat is taken.
module context_load_store_elimination import cls_pkg::*; #(
  parameter int unsigned CONTEXT_BYTES    = 1024,
  parameter int unsigned MAX_ACCESS_BYTES = 8,
  parameter int unsigned VALUE_ID_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pass_mode_we_i,
  input  logic        pass_mode_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [9:0]  offset_i,
  input  logic [3:0]  size_bytes_i,
  input  logic [3:0]  type_code_i,
  input  logic [15:0] value_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        remove_o,
  output logic [15:0] reuse_value_o,
  output logic        range_error_o
);

  cls_cmd_t  cmd;
  cls_stat_t stat;

  // Sequencing.
  cls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Table and result.
  cls_datapath #(
    .CONTEXT_BYTES    (CONTEXT_BYTES),
    .MAX_ACCESS_BYTES (MAX_ACCESS_BYTES),
    .VALUE_ID_BITS    (VALUE_ID_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .pass_mode_we_i (pass_mode_we_i),
    .pass_mode_i    (pass_mode_i),
    .operation_i    (operation_i),
    .offset_i       (offset_i),
    .size_bytes_i   (size_bytes_i),
    .type_code_i    (type_code_i),
    .value_id_i     (value_id_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .remove_o       (remove_o),
    .reuse_value_o  (reuse_value_o),
    .range_error_o  (range_error_o)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the context load/store elimination block.
`timescale 1ns / 100ps

module testbench import cls_pkg::*; ;

  localparam int unsigned AREA = 1024;
  localparam int unsigned MAX_SIZE = 8;
  localparam longint unsigned LIMIT = 3000000;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  offset;
    logic [3:0]  size;
    logic [3:0]  ty;
    logic [15:0] vid;
  } access_t;

  typedef struct packed {
    logic        remove;
    logic [15:0] reuse;
    logic        rerr;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        pass_mode_we_i = 1'b0;
  logic        pass_mode_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = '0;
  logic [9:0]  offset_i = '0;
  logic [3:0]  size_bytes_i = '0;
  logic [3:0]  type_code_i = '0;
  logic [15:0] value_id_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        remove_o;
  logic [15:0] reuse_value_o;
  logic        range_error_o;

  context_load_store_elimination dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .pass_mode_we_i(pass_mode_we_i), .pass_mode_i(pass_mode_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .operation_i(operation_i), .offset_i(offset_i), .size_bytes_i(size_bytes_i),
    .type_code_i(type_code_i), .value_id_i(value_id_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .remove_o(remove_o), .reuse_value_o(reuse_value_o), .range_error_o(range_error_o)
  );

  always #1 clk_i = ~clk_i;

  // Predictor copy of the byte table and the mode register.
  logic        tbl_valid [AREA];
  logic [9:0]  tbl_start [AREA];
  logic [15:0] tbl_value [AREA];
  logic [3:0]  tbl_type  [AREA];
  logic [3:0]  tbl_size  [AREA];
  logic        elim_stores;

  access_t  pending_accesses[$];
  verdict_t expected_verdicts[$];
  int       idle_pct = 0;
  int       stall_pct = 0;
  bit       failed = 0;
  longint unsigned cycles = 0;

  // Writes one entry over a byte range.
  function automatic void record_range(access_t a, logic v);
    for (int i = 0; i < a.size; i++) begin
      tbl_valid[a.offset + i] = v;
      tbl_start[a.offset + i] = v ? a.offset : '0;
      tbl_value[a.offset + i] = v ? a.vid : '0;
      tbl_type[a.offset + i]  = v ? a.ty : '0;
      tbl_size[a.offset + i]  = v ? a.size : '0;
    end
  endfunction

  // Computes the verdict on one access and updates the table.
  function automatic verdict_t judge_access(access_t a);
    verdict_t r;
    int n;
    bit hit;
    r = '0;
    if (a.op == OP_BARRIER) begin
      for (int i = 0; i < AREA; i++) tbl_valid[i] = 1'b0;
    end else if (a.op == OP_LOAD || a.op == OP_STORE) begin
      if (a.size == 0 || a.size > MAX_SIZE || int'(a.offset) + int'(a.size) > AREA) begin
        r.rerr = 1'b1;
      end else if (!elim_stores) begin
        hit = 0;
        if (a.op == OP_LOAD && tbl_valid[a.offset] && tbl_start[a.offset] == a.offset) begin
          n = int'(tbl_size[a.offset]);
          hit = n != 0 && int'(a.offset) + n <= AREA && tbl_type[a.offset] == a.ty;
          for (int i = 0; i < n && hit; i++)
            if (!tbl_valid[a.offset + i] || tbl_value[a.offset + i] != tbl_value[a.offset])
              hit = 0;
        end
        if (hit) begin
          r.remove = 1'b1;
          r.reuse = tbl_value[a.offset];
        end else begin
          record_range(a, 1'b1);
        end
      end else if (a.op == OP_LOAD) begin
        record_range(a, 1'b0);
      end else begin
        hit = 1;
        for (int i = 0; i < a.size; i++) if (!tbl_valid[a.offset + i]) hit = 0;
        if (hit) r.remove = 1'b1;
        else record_range(a, 1'b1);
      end
    end
    return r;
  endfunction

  // Driver: presents queued beats, holding each until accepted.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    out_stall_i <= ($urandom_range(99) < stall_pct);
    if (!in_valid_i || !in_stall_o) begin
      if (pending_accesses.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_valid_i   <= 1'b1;
        operation_i  <= pending_accesses[0].op;
        offset_i     <= pending_accesses[0].offset;
        size_bytes_i <= pending_accesses[0].size;
        type_code_i  <= pending_accesses[0].ty;
        value_id_i   <= pending_accesses[0].vid;
        expected_verdicts.push_back(judge_access(pending_accesses.pop_front()));
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks every accepted result beat against the oldest verdict.
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result beat remove=%0d reuse=%0d err=%0d",
                 $time, remove_o, reuse_value_o, range_error_o);
        failed = 1;
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (remove_o !== exp_v.remove) begin
          $display("%0t: remove expected %0d actual %0d", $time, exp_v.remove, remove_o);
          failed = 1;
        end
        if (reuse_value_o !== exp_v.reuse) begin
          $display("%0t: reuse_value expected %0d actual %0d", $time, exp_v.reuse,
                   reuse_value_o);
          failed = 1;
        end
        if (range_error_o !== exp_v.rerr) begin
          $display("%0t: range_error expected %0d actual %0d", $time, exp_v.rerr,
                   range_error_o);
          failed = 1;
        end
      end
    end
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("context_load_store_elimination test failed");
      $finish;
    end
  end

  function automatic access_t make_access(logic [1:0] op, int off, int sz, int ty, int vid);
    access_t a;
    a.op = op;
    a.offset = 10'(off);
    a.size = 4'(sz);
    a.ty = 4'(ty);
    a.vid = 16'(vid);
    return a;
  endfunction

  // Random access, mostly well-formed and clustered in a small window.
  function automatic access_t random_access(int base);
    int pick;
    int sz;
    pick = $urandom_range(99);
    sz = $urandom_range(1, MAX_SIZE);
    if (pick < 6) return make_access(OP_BARRIER, $urandom, $urandom, $urandom, $urandom);
    if (pick < 9) return make_access(2'($urandom_range(3)), $urandom, $urandom, $urandom,
                                     $urandom);
    if (pick < 12) return make_access(2'($urandom_range(1, 2)),
                                      $urandom_range(AREA - 8, AREA - 1),
                                      sz, $urandom_range(15), $urandom);
    return make_access(2'($urandom_range(1, 2)),
                       base + $urandom_range(0, 6) * $urandom_range(1, 4),
                       $urandom_range(0, 3) == 0 ? sz : 4, $urandom_range(0, 2), $urandom);
  endfunction

  task automatic wait_drained();
    while (pending_accesses.size() > 0 || expected_verdicts.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    @(posedge clk_i);
    pass_mode_we_i <= 1'b1;
    pass_mode_i    <= m;
    elim_stores = m;
    @(posedge clk_i);
    pass_mode_we_i <= 1'b0;
  endtask

  // Stimulus: directed extremes, then random phases across both modes.
  initial begin
    int base;
    for (int i = 0; i < AREA; i++) begin
      tbl_valid[i] = '0; tbl_start[i] = '0; tbl_value[i] = '0; tbl_type[i] = '0;
      tbl_size[i] = '0;
    end
    elim_stores = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Load mode: reuse, type mismatch, partial overwrite, bad sizes, end of area.
    pending_accesses.push_back(make_access(OP_STORE, 0, 8, 15, 16'hFFFF));
    pending_accesses.push_back(make_access(OP_LOAD, 0, 8, 15, 1));
    pending_accesses.push_back(make_access(OP_LOAD, 0, 8, 3, 2));
    pending_accesses.push_back(make_access(OP_STORE, 4, 2, 3, 0));
    pending_accesses.push_back(make_access(OP_LOAD, 0, 8, 3, 5));
    pending_accesses.push_back(make_access(OP_LOAD, 1016, 8, 1, 7));
    pending_accesses.push_back(make_access(OP_LOAD, 1016, 8, 1, 8));
    pending_accesses.push_back(make_access(OP_LOAD, 1020, 8, 1, 9));
    pending_accesses.push_back(make_access(OP_LOAD, 10, 0, 1, 9));
    pending_accesses.push_back(make_access(OP_STORE, 10, 9, 1, 9));
    pending_accesses.push_back(make_access(OP_STORE, 1023, 15, 1, 9));
    pending_accesses.push_back(make_access(OP_UNUSED, 1023, 15, 15, 16'hFFFF));
    pending_accesses.push_back(make_access(OP_BARRIER, 0, 0, 0, 0));
    pending_accesses.push_back(make_access(OP_LOAD, 1016, 8, 1, 8));
    pending_accesses.push_back(make_access(OP_LOAD, 1023, 1, 0, 0));
    wait_drained();

    // Store mode: dead store, load erasure, partial cover.
    write_mode(1'b1);
    pending_accesses.push_back(make_access(OP_STORE, 100, 4, 1, 11));
    pending_accesses.push_back(make_access(OP_STORE, 104, 4, 1, 12));
    pending_accesses.push_back(make_access(OP_STORE, 100, 8, 2, 13));
    pending_accesses.push_back(make_access(OP_LOAD, 102, 2, 2, 14));
    pending_accesses.push_back(make_access(OP_STORE, 100, 8, 2, 15));
    pending_accesses.push_back(make_access(OP_STORE, 100, 8, 2, 16));
    pending_accesses.push_back(make_access(OP_STORE, 1020, 8, 2, 16));
    pending_accesses.push_back(make_access(OP_BARRIER, 0, 0, 0, 0));
    pending_accesses.push_back(make_access(OP_STORE, 100, 8, 2, 17));
    wait_drained();

    // Random phases with changing idle and stall pressure.
    for (int ph = 0; ph < 8; ph++) begin
      write_mode(ph % 3 == 1);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      base = $urandom_range(0, 1) ? $urandom_range(0, 32) : $urandom_range(0, AREA - 40);
      for (int i = 0; i < 170; i++) begin
        if (i % 60 == 59) base = $urandom_range(0, AREA - 40);
        pending_accesses.push_back(random_access(base));
      end
      wait_drained();
    end

    if (failed)
      $display("context_load_store_elimination test failed");
    else
      $display("context_load_store_elimination test passed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/cls_pkg.sv
sv/cls_ram.sv
sv/cls_datapath.sv
sv/cls_ctrl.sv
sv/context_load_store_elimination.sv
tb/sv/testbench.sv
